### src/bzy_pkg.sv
// Package for the cubic Bezier easing solver.
// Holds the Q4.15 types, the saturation function, the sequencer states and constants.
// Used by bzy_qmul and bezier_easing_y_from_x.
package bzy_pkg;

  localparam int QW       = 20;
  localparam int ACC_W    = 26;
  localparam int ITER_DEF = 12;
  localparam int TOL_W    = 11;

  typedef logic signed [QW-1:0]    q_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam q_t          Q_MAX      = q_t'(524287);
  localparam q_t          Q_MIN      = q_t'(-524288);
  localparam logic [15:0] ONE_Q15    = 16'd32768;
  localparam logic [TOL_W-1:0] TOL_RESET = 11'd16;
  localparam logic        REG_TOLERANCE = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T2,
    S_T3,
    S_P0,
    S_P1,
    S_P2,
    S_CHK,
    S_F_T2,
    S_F_T3,
    S_F_A,
    S_F_B,
    S_F_C,
    S_F_D,
    S_F_E,
    S_F_Y,
    S_OUT
  } state_e;

  function automatic q_t sat_q(input acc_t v);
    q_t res;
    if (v > acc_t'(Q_MAX)) begin
      res = Q_MAX;
    end else if (v < acc_t'(Q_MIN)) begin
      res = Q_MIN;
    end else begin
      res = v[QW-1:0];
    end
    return res;
  endfunction

endpackage

### src/bzy_qmul.sv
// Shared Q4.15 multiplier: product, round half up, floor shift by 15, saturation.
// Depends on bzy_pkg.
module bzy_qmul import bzy_pkg::*; (
  input  q_t a_i,
  input  q_t b_i,
  output q_t p_o
);

  logic signed [2*QW-1:0] prod;
  logic signed [2*QW:0]   rnd;

  always_comb begin
    prod = a_i * b_i;
    rnd  = (2*QW+1)'(prod) + (2*QW+1)'(16384);
    p_o  = sat_q(rnd[2*QW:15]);
  end

endmodule

### src/bezier_easing_y_from_x.sv
// Cubic Bezier easing solver: maps a position x to the eased value y of the curve.
// Depends on bzy_pkg and bzy_qmul.
//
// One word is taken at a time. A word whose control points both lie on the diagonal
// goes straight from idle to the output state. Any other word is loaded, then runs
// through Newton-style corrections of t (at most ITERATIONS of them, 12 by default,
// each through states T2, T3, P0, P1, P2 and CHK) and the evaluation of y. The single
// shared 20x20 multiplier performs one multiplication per cycle under the
// sequencer. A finished result waits in the output register while the next word is taken.
module bezier_easing_y_from_x import bzy_pkg::*; #(
  parameter int ITERATIONS = ITER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] first_ctrl_x_i,
  input  logic [15:0] first_ctrl_y_i,
  input  logic [15:0] second_ctrl_x_i,
  input  logic [15:0] second_ctrl_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] eased_y_o,
  output logic        converged_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(ITERATIONS + 1);

  state_e state_q, state_d;

  logic [TOL_W-1:0] tol_q;
  logic [IW-1:0]    iter_q;
  logic [15:0]      x_q;
  q_t   k0_q, k1_q, k2_q, ay_q, by_q;
  q_t   t_q, t2_q, t3_q, r_q, m_q;
  acc_t acc_q;
  logic conv_q;
  logic [15:0] y_q;
  logic out_valid_q, converged_q;
  logic [15:0] eased_y_q;

  logic in_acc, out_free, load_out, last_iter, diag;
  q_t   mul_a, mul_b, mul_p;
  q_t   f_val, tol_s, t_new, s3, y_fin;
  acc_t ax_w, bx_w;

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TOLERANCE) begin
      prdata = {{(32-TOL_W){1'b0}}, tol_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOLERANCE) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  // Shared multiplier
  bzy_qmul u_qmul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_T2, S_F_T2: begin mul_a = t_q;  mul_b = t_q;  end
      S_T3, S_F_T3: begin mul_a = t2_q; mul_b = t_q;  end
      S_P0:         begin mul_a = k0_q; mul_b = t3_q; end
      S_P1:         begin mul_a = k1_q; mul_b = t2_q; end
      S_P2:         begin mul_a = k2_q; mul_b = t_q;  end
      S_F_A:        begin mul_a = t2_q; mul_b = r_q;  end
      S_F_B:        begin mul_a = m_q;  mul_b = by_q; end
      S_F_C:        begin mul_a = r_q;  mul_b = r_q;  end
      S_F_D:        begin mul_a = t_q;  mul_b = m_q;  end
      S_F_E:        begin mul_a = m_q;  mul_b = ay_q; end
      default:      begin mul_a = '0;   mul_b = '0;   end
    endcase
  end

  // Datapath arithmetic around the multiplier
  always_comb begin
    diag  = (first_ctrl_x_i == first_ctrl_y_i) && (second_ctrl_x_i == second_ctrl_y_i);
    ax_w  = $signed({{(ACC_W-16){1'b0}}, first_ctrl_x_i});
    bx_w  = $signed({{(ACC_W-16){1'b0}}, second_ctrl_x_i});
    f_val = sat_q(acc_q);
    tol_s = $signed({{(QW-TOL_W){1'b0}}, tol_q});
    t_new = sat_q(acc_t'(t_q) - acc_t'(f_val >>> 1));
    s3    = sat_q(acc_t'(m_q) + acc_t'(m_q) + acc_t'(m_q));
    y_fin = sat_q(acc_q + acc_t'(s3));
    last_iter = (iter_q == IW'(ITERATIONS - 1));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = diag ? S_OUT : S_T2;
        end
      end
      S_T2:   state_d = S_T3;
      S_T3:   state_d = S_P0;
      S_P0:   state_d = S_P1;
      S_P1:   state_d = S_P2;
      S_P2:   state_d = S_CHK;
      S_CHK: begin
        if ((f_val <= tol_s) && (f_val >= -tol_s)) begin
          state_d = S_F_T2;
        end else if (last_iter) begin
          state_d = S_F_T2;
        end else begin
          state_d = S_T2;
        end
      end
      S_F_T2: state_d = S_F_T3;
      S_F_T3: state_d = S_F_A;
      S_F_A:  state_d = S_F_B;
      S_F_B:  state_d = S_F_C;
      S_F_C:  state_d = S_F_D;
      S_F_D:  state_d = S_F_E;
      S_F_E:  state_d = S_F_Y;
      S_F_Y:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    in_acc     = in_valid_i && !in_stall_o;
    out_free   = !out_valid_q || !out_stall_i;
    load_out   = (state_q == S_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
      conv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        iter_q <= '0;
        conv_q <= diag;
      end else if (state_q == S_CHK) begin
        if ((f_val <= tol_s) && (f_val >= -tol_s)) begin
          conv_q <= 1'b1;
        end else begin
          iter_q <= iter_q + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_q  <= pos_x_i;
          t_q  <= $signed({{(QW-16){1'b0}}, pos_x_i});
          ay_q <= $signed({{(QW-16){1'b0}}, first_ctrl_y_i});
          by_q <= $signed({{(QW-16){1'b0}}, second_ctrl_y_i});
          k0_q <= sat_q(acc_t'(acc_t'(ONE_Q15) + 3 * ax_w - 3 * bx_w));
          k1_q <= sat_q(acc_t'(3 * bx_w - 6 * ax_w));
          k2_q <= sat_q(acc_t'(3 * ax_w));
          y_q  <= (pos_x_i > ONE_Q15) ? ONE_Q15 : pos_x_i;
        end
      end
      S_T2:  t2_q  <= mul_p;
      S_T3:  t3_q  <= mul_p;
      S_P0:  acc_q <= acc_t'(mul_p) - $signed({{(ACC_W-16){1'b0}}, x_q});
      S_P1:  acc_q <= acc_q + acc_t'(mul_p);
      S_P2:  acc_q <= acc_q + acc_t'(mul_p);
      S_CHK: begin
        if (!((f_val <= tol_s) && (f_val >= -tol_s))) begin
          t_q <= t_new;
        end
      end
      S_F_T2: begin
        t2_q <= mul_p;
        r_q  <= sat_q(acc_t'(ONE_Q15) - acc_t'(t_q));
      end
      S_F_T3: t3_q <= mul_p;
      S_F_A:  m_q  <= mul_p;
      S_F_B:  m_q  <= mul_p;
      S_F_C: begin
        acc_q <= acc_t'(sat_q(acc_t'(t3_q) + acc_t'(s3)));
        m_q   <= mul_p;
      end
      S_F_D:  m_q <= mul_p;
      S_F_E:  m_q <= mul_p;
      S_F_Y: begin
        if (y_fin < 0) begin
          y_q <= '0;
        end else if (y_fin > $signed({{(QW-16){1'b0}}, ONE_Q15})) begin
          y_q <= ONE_Q15;
        end else begin
          y_q <= y_fin[15:0];
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      eased_y_q   <= y_q;
      converged_q <= conv_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign eased_y_o   = eased_y_q;
  assign converged_o = converged_q;

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (iter_q <= IW'(ITERATIONS)))
    else $error("iteration counter beyond its bound");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("sequencer idle right after a word was taken");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (eased_y_o <= ONE_Q15))
    else $error("eased value beyond one");

endmodule
